FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/cct_pkg.sv
package cct_pkg;

    localparam int CCT_SAMPLE_BITS = 32;
    localparam int CCT_TOTAL_W     = 64;
    // Widest divisor is 1023 * 10^6, which stays below 2^30.
    localparam int CCT_DIV_W       = 30;
    // Seconds quotient is below 2^(SAMPLE_BITS + 13) since the divisor is at least 10^6.
    localparam int CCT_SEC_STEPS   = CCT_SAMPLE_BITS + 13;
    // Millisecond and microsecond quotients are below 1024.
    localparam int CCT_FRAC_STEPS  = 10;
    localparam int CCT_CNT_W       = $clog2(CCT_SEC_STEPS + 1);
    localparam int CCT_IDX_W       = 2;
    localparam int CCT_MHZ_W       = 10;
    localparam int CCT_MS_DIV_W    = 20;

    localparam logic [31:0] CCT_SAMPLE_MASK =
        32'((64'd1 << CCT_SAMPLE_BITS) - 64'd1);
    localparam logic [19:0] CCT_HZ_PER_MHZ  = 20'd1000000;
    localparam logic [9:0]  CCT_KHZ_PER_MHZ = 10'd1000;

    localparam logic [CCT_IDX_W-1:0] CCT_REG_ENABLE = 2'd0;
    localparam logic [CCT_IDX_W-1:0] CCT_REG_CLOCK  = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEC  = 5'b00010,
        ST_MSEC = 5'b00100,
        ST_USEC = 5'b01000,
        ST_HOLD = 5'b10000
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [CCT_DIV_W-1:0]   init_rem;
        logic [CCT_TOTAL_W-1:0] init_quo;
        logic [CCT_DIV_W-1:0]   divisor;
        logic [CCT_CNT_W-1:0]   steps;
    } t_div_cmd;

    typedef struct packed {
        logic                   done;
        logic [CCT_TOTAL_W-1:0] quo;
        logic [CCT_DIV_W-1:0]   rem;
    } t_div_stat;

endpackage

FILE: rtl/core/cct_in_if.sv
interface cct_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] cycle_count;

    modport source (output valid, output cycle_count, input ready);
    modport sink   (input valid, input cycle_count, output ready);
endinterface

FILE: rtl/core/cct_out_if.sv
interface cct_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] ext_cycles;
    logic [31:0] seconds;
    logic [9:0]  milliseconds;
    logic [9:0]  microseconds;

    modport source (output valid, output ext_cycles, output seconds,
                    output milliseconds, output microseconds, input ready);
    modport sink   (input valid, input ext_cycles, input seconds,
                    input milliseconds, input microseconds, output ready);
endinterface

FILE: rtl/core/cct_div.sv
module cct_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cct_pkg::t_div_cmd  i_cmd,
    output cct_pkg::t_div_stat o_stat
);
    import cct_pkg::*;

    logic [CCT_DIV_W-1:0]   r_rem, n_rem;
    logic [CCT_TOTAL_W-1:0] r_quo, n_quo;
    logic [CCT_DIV_W-1:0]   r_div, n_div;
    logic [CCT_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;

    logic [CCT_DIV_W:0] w_trial;
    logic [CCT_DIV_W:0] w_diff;
    logic               w_ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign w_trial = {r_rem, r_quo[CCT_TOTAL_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_rem  = i_cmd.init_rem;
            n_quo  = i_cmd.init_quo;
            n_div  = i_cmd.divisor;
            n_cnt  = i_cmd.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[CCT_DIV_W-1:0] : w_trial[CCT_DIV_W-1:0];
            n_quo = {r_quo[CCT_TOTAL_W-2:0], w_ge};
            n_cnt = r_cnt - CCT_CNT_W'(1);
            if (r_cnt == CCT_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;
    assign o_stat.rem  = r_rem;

endmodule

FILE: rtl/core/cycle_counter_timeline.sv
// Extends samples of a wrapping cycle counter to a 64-bit count and splits it
// into seconds, milliseconds and microseconds at the configured clock. One
// shared bit-serial divider does three divisions in turn: 45 steps for the
// seconds (SAMPLE_BITS + 13 in general) and 10 steps each for milliseconds and
// microseconds. A new sample is taken only once the previous one has been
// through all three divisions and its result is in the output register, so
// a result waiting there holds off the next sample. While idle and disabled,
// samples are taken at one per cycle and dropped. Configuration writes take
// effect at once and do not clear the wrap count or the last sample.
module cycle_counter_timeline (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cct_pkg::CCT_IDX_W-1:0] i_cfg_idx,
    input  logic [cct_pkg::CCT_MHZ_W-1:0] i_cfg_data,
    cct_in_if.sink                        i_sample,
    cct_out_if.source                     o_result
);
    import cct_pkg::*;

    t_state                 r_state, n_state;
    logic                   r_enable;
    logic [CCT_MHZ_W-1:0]   r_clock_mhz;
    logic [31:0]            r_wrap, n_wrap;
    logic [31:0]            r_last, n_last;
    logic [CCT_TOTAL_W-1:0] r_total, n_total;
    logic [31:0]            r_secs, n_secs;
    logic [9:0]             r_msec, n_msec;
    logic                   r_out_valid, n_out_valid;
    logic [CCT_TOTAL_W-1:0] r_out_total;
    logic [31:0]            r_out_secs;
    logic [9:0]             r_out_ms;
    logic [9:0]             r_out_us;

    logic [CCT_MHZ_W-1:0]    w_mhz;
    logic [CCT_DIV_W-1:0]    w_hz;
    logic [CCT_MS_DIV_W-1:0] w_per_ms;
    logic [31:0]             w_sample;
    logic [31:0]             w_wrap_upd;
    logic [CCT_TOTAL_W-1:0]  w_total;
    logic                    w_take;
    logic                    w_out_free;
    logic                    w_load;
    t_div_cmd                w_cmd;
    t_div_stat               w_stat;

    cct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    // A zero clock setting is run as 1 MHz so no divisor is ever zero.
    assign w_mhz    = (r_clock_mhz == '0) ? CCT_MHZ_W'(1) : r_clock_mhz;
    assign w_hz     = CCT_DIV_W'(w_mhz * CCT_HZ_PER_MHZ);
    assign w_per_ms = CCT_MS_DIV_W'(w_mhz * CCT_KHZ_PER_MHZ);

    assign i_sample.ready = (r_state == ST_IDLE);
    assign w_take         = i_sample.valid && i_sample.ready;

    assign w_sample   = i_sample.cycle_count & CCT_SAMPLE_MASK;
    assign w_wrap_upd = (w_sample < r_last) ? r_wrap + 32'd1 : r_wrap;
    // The sample lies below 2^SAMPLE_BITS, so OR is the same as the add.
    assign w_total    = ({32'b0, w_wrap_upd} << CCT_SAMPLE_BITS) | {32'b0, w_sample};

    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        n_wrap  = r_wrap;
        n_last  = r_last;
        n_total = r_total;
        n_secs  = r_secs;
        n_msec  = r_msec;
        w_load  = 1'b0;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && r_enable) begin
                    n_wrap         = w_wrap_upd;
                    n_last         = w_sample;
                    n_total        = w_total;
                    w_cmd.start    = 1'b1;
                    w_cmd.init_rem = CCT_DIV_W'(w_total >> CCT_SEC_STEPS);
                    w_cmd.init_quo = w_total << (CCT_TOTAL_W - CCT_SEC_STEPS);
                    w_cmd.divisor  = w_hz;
                    w_cmd.steps    = CCT_CNT_W'(CCT_SEC_STEPS);
                    n_state        = ST_SEC;
                end
            end
            ST_SEC: begin
                if (w_stat.done) begin
                    n_secs         = w_stat.quo[31:0];
                    w_cmd.start    = 1'b1;
                    w_cmd.init_rem = w_stat.rem >> CCT_FRAC_STEPS;
                    w_cmd.init_quo = {w_stat.rem[CCT_FRAC_STEPS-1:0],
                                      (CCT_TOTAL_W - CCT_FRAC_STEPS)'(0)};
                    w_cmd.divisor  = CCT_DIV_W'(w_per_ms);
                    w_cmd.steps    = CCT_CNT_W'(CCT_FRAC_STEPS);
                    n_state        = ST_MSEC;
                end
            end
            ST_MSEC: begin
                if (w_stat.done) begin
                    n_msec         = w_stat.quo[9:0];
                    w_cmd.start    = 1'b1;
                    w_cmd.init_rem = w_stat.rem >> CCT_FRAC_STEPS;
                    w_cmd.init_quo = {w_stat.rem[CCT_FRAC_STEPS-1:0],
                                      (CCT_TOTAL_W - CCT_FRAC_STEPS)'(0)};
                    w_cmd.divisor  = CCT_DIV_W'(w_mhz);
                    w_cmd.steps    = CCT_CNT_W'(CCT_FRAC_STEPS);
                    n_state        = ST_USEC;
                end
            end
            ST_USEC: begin
                if (w_stat.done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // The divider keeps its last quotient until the next start.
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_clock_mhz <= CCT_MHZ_W'(72);
            r_wrap      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wrap      <= n_wrap;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CCT_REG_ENABLE: r_enable    <= i_cfg_data[0];
                    CCT_REG_CLOCK:  r_clock_mhz <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_secs  <= n_secs;
        r_msec  <= n_msec;
        if (w_load) begin
            r_out_total <= r_total;
            r_out_secs  <= r_secs;
            r_out_ms    <= r_msec;
            r_out_us    <= w_stat.quo[9:0];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.ext_cycles   = r_out_total;
    assign o_result.seconds      = r_out_secs;
    assign o_result.milliseconds = r_out_ms;
    assign o_result.microseconds = r_out_us;

endmodule

FILE: rtl/core/cct_checker.sv
`include "assert_macros.svh"

module cct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [9:0]  i_cfg_data,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_total,
    input logic [9:0]  i_out_ms,
    input logic [9:0]  i_out_us
);
    import cct_pkg::*;

    logic r_enable;

    // Mirror of the enable register, seen from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == CCT_REG_ENABLE) begin
            r_enable <= i_cfg_data[0];
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_total))
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready && r_enable, !i_in_ready)
    `ASSERT_IMPLIES(a_ms_range, i_clk, i_rst_n, i_out_valid, i_out_ms <= 10'd999)
    `ASSERT_IMPLIES(a_us_range, i_clk, i_rst_n, i_out_valid, i_out_us <= 10'd999)

endmodule

bind cycle_counter_timeline cct_checker u_cct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_total (o_result.ext_cycles),
    .i_out_ms    (o_result.milliseconds),
    .i_out_us    (o_result.microseconds)
);
